/* design/prbe_pkg.sv */
// Shared types and constants for the packet ring buffer engine.
`default_nettype none

package prbe_pkg;

  // Field widths fixed by the request and result formats.
  localparam int LEN_W   = 12;
  localparam int CFG_W   = 13;
  localparam int AVAIL_W = 13;

  // Trailer length and the smallest usable ring size.
  localparam int TRAILER_BYTES = 8;
  localparam int MIN_SIZE      = 16;

  // Request mode codes.
  localparam logic [2:0] MODE_WSTART = 3'd0;
  localparam logic [2:0] MODE_WBYTE  = 3'd1;
  localparam logic [2:0] MODE_RSTART = 3'd2;
  localparam logic [2:0] MODE_PSTART = 3'd3;
  localparam logic [2:0] MODE_RBYTE  = 3'd4;

  typedef logic [LEN_W-1:0]   len_t;
  typedef logic [AVAIL_W-1:0] avail_t;
  typedef logic [CFG_W-1:0]   cfg_size_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_AGAIN   = 2'd1,
    ST_INVALID = 2'd2,
    ST_SEQ     = 2'd3
  } status_t;

  // Operation class decided by the front end.
  typedef enum logic [2:0] {
    OP_WSTART,
    OP_WBYTE,
    OP_RSTART,
    OP_PSTART,
    OP_RBYTE,
    OP_BAD
  } op_t;

  // One request as it arrives on the input port.
  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] data_byte;
    len_t       length;
    len_t       skip_offset;
  } in_req_t;

  // One result as it leaves on the output port.
  typedef struct packed {
    status_t    status;
    logic [7:0] read_data;
    logic       last;
    avail_t     avail_read;
    avail_t     avail_write;
  } out_rsp_t;

  // A classified request held in the queue.
  typedef struct packed {
    op_t        op;
    logic [7:0] data_byte;
    len_t       length;
    len_t       skip_offset;
    logic       len_zero;
  } q_item_t;

  // Head of the queue as seen by the back end.
  typedef struct packed {
    logic    valid;
    q_item_t item;
  } q_fwd_t;

endpackage

`default_nettype wire

/* design/prbe_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module prbe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

/* design/prbe_front.sv */
// Front end: accepts requests, classifies them and holds them in a short queue.
`default_nettype none

module prbe_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire prbe_pkg::in_req_t in_req,
  output prbe_pkg::q_fwd_t       q_fwd,
  input  wire logic              q_pop
);

  localparam int Q_DEPTH = 2;

  prbe_pkg::q_item_t q_mem_r [Q_DEPTH];
  logic [1:0]        cnt_r, cnt_nxt;
  logic              wr_ptr_r, wr_ptr_nxt;
  logic              rd_ptr_r, rd_ptr_nxt;
  logic              push;
  prbe_pkg::q_item_t item_w;

  // Decode the mode into an operation class.
  always_comb begin
    item_w.data_byte   = in_req.data_byte;
    item_w.length      = in_req.length;
    item_w.skip_offset = in_req.skip_offset;
    item_w.len_zero    = (in_req.length == '0);
    unique case (in_req.mode)
      prbe_pkg::MODE_WSTART: item_w.op = prbe_pkg::OP_WSTART;
      prbe_pkg::MODE_WBYTE:  item_w.op = prbe_pkg::OP_WBYTE;
      prbe_pkg::MODE_RSTART: item_w.op = prbe_pkg::OP_RSTART;
      prbe_pkg::MODE_PSTART: item_w.op = prbe_pkg::OP_PSTART;
      prbe_pkg::MODE_RBYTE:  item_w.op = prbe_pkg::OP_RBYTE;
      default:               item_w.op = prbe_pkg::OP_BAD;
    endcase
  end

  // Queue pointers and fill count.
  assign busy = (cnt_r == 2'(Q_DEPTH));
  assign push = start && !busy;

  always_comb begin
    wr_ptr_nxt = push  ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      cnt_r    <= cnt_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= item_w;
    end
  end

  assign q_fwd.valid = (cnt_r != '0);
  assign q_fwd.item  = q_mem_r[rd_ptr_r];

endmodule

`default_nettype wire

/* design/prbe_back.sv */
// Back end: executes queued requests against the ring indices and the ring memory.
`default_nettype none

module prbe_back #(
  parameter int RING_BYTES = 4096
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire prbe_pkg::q_fwd_t    q_fwd,
  output logic                     q_pop,
  input  wire logic                cfg_we,
  input  wire prbe_pkg::cfg_size_t cfg_data,
  output logic                     out_valid,
  output prbe_pkg::out_rsp_t       out_rsp
);

  localparam int AW    = $clog2(RING_BYTES);
  localparam int SW    = $clog2(RING_BYTES + 1);
  localparam int CW    = (SW > prbe_pkg::CFG_W) ? SW : prbe_pkg::CFG_W;
  localparam int CMPW  = CW + 1;
  localparam int MW    = ((AW > prbe_pkg::LEN_W) ? AW : prbe_pkg::LEN_W) + 1;
  localparam int NSTEP = MW - 4;
  localparam int MCW   = $clog2(NSTEP);
  localparam int DW    = SW + NSTEP - 1;
  localparam int AVW   = prbe_pkg::AVAIL_W;
  localparam int LW    = prbe_pkg::LEN_W;

  typedef enum logic [1:0] {S_IDLE, S_MOD, S_TRAIL, S_RDWAIT} state_t;
  typedef enum logic [1:0] {PH_IDLE, PH_WRITE, PH_READ, PH_PEEK} phase_t;

  state_t            st_r, st_nxt;
  phase_t            phase_r, phase_nxt;
  logic [SW-1:0]     size_r, size_nxt;
  logic [AW-1:0]     wpos_r, wpos_nxt;
  logic [AW-1:0]     rpos_r, rpos_nxt;
  logic [AW-1:0]     work_r, work_nxt;
  logic [LW-1:0]     left_r, left_nxt;
  logic [2:0]        tcnt_r, tcnt_nxt;
  logic [MW-1:0]     modv_r, modv_nxt;
  logic [DW-1:0]     den_r, den_nxt;
  logic [MCW-1:0]    mcnt_r, mcnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  prbe_pkg::status_t out_st_r, out_st_nxt;
  logic              out_last_r, out_last_nxt;
  logic [7:0]        out_data_r, out_data_nxt;

  logic [SW-1:0]     wext, rext, free_w, rdbl_w;
  logic              room_fail, data_short;
  logic [SW-1:0]     work_plus;
  logic [AW-1:0]     work_inc;
  logic [SW:0]       rd_commit_sum;
  logic [AW-1:0]     rd_commit;
  logic [CW-1:0]     cfg_ext, cfg_clamp;
  logic [31:0]       wpos32;
  logic [7:0]        trail_byte;
  logic [DW-1:0]     modv_ext;
  logic [MW-1:0]     modv_step;
  logic              ram_we, ram_re;
  logic [7:0]        ram_wdata, ram_rdata;
  prbe_pkg::q_item_t item;

  assign item = q_fwd.item;

  // Free and readable byte counts from the committed indices.
  always_comb begin
    wext   = SW'(wpos_r);
    rext   = SW'(rpos_r);
    free_w = (wpos_r >= rpos_r) ? (size_r - (wext - rext)) : (rext - wext);
    rdbl_w = size_r - free_w;
  end

  // Room and data checks for start requests.
  assign room_fail  = CMPW'(free_w) <= (CMPW'(item.length) + CMPW'(prbe_pkg::TRAILER_BYTES));
  assign data_short = CMPW'(rdbl_w) < CMPW'(item.length);

  // Work index advance with wrap at the ring size.
  always_comb begin
    work_plus = SW'(work_r) + SW'(1);
    work_inc  = (work_plus == size_r) ? '0 : AW'(work_plus);
  end

  // Read index after a committed read: past the run and its trailer.
  always_comb begin
    rd_commit_sum = (SW + 1)'(work_r) + (SW + 1)'(prbe_pkg::TRAILER_BYTES);
    if (rd_commit_sum >= (SW + 1)'(size_r)) begin
      rd_commit = AW'(rd_commit_sum - (SW + 1)'(size_r));
    end else begin
      rd_commit = AW'(rd_commit_sum);
    end
  end

  // Ring size saturated to the supported range.
  always_comb begin
    cfg_ext = CW'(cfg_data);
    if (cfg_ext < CW'(prbe_pkg::MIN_SIZE)) begin
      cfg_clamp = CW'(prbe_pkg::MIN_SIZE);
    end else if (cfg_ext > CW'(RING_BYTES)) begin
      cfg_clamp = CW'(RING_BYTES);
    end else begin
      cfg_clamp = cfg_ext;
    end
  end

  // Trailer: four zero bytes, then the packet's start index little endian.
  always_comb begin
    wpos32 = 32'(wpos_r);
    if (tcnt_r[2]) begin
      trail_byte = wpos32[8*tcnt_r[1:0] +: 8];
    end else begin
      trail_byte = '0;
    end
  end

  // One restoring step of the skip offset modulo.
  always_comb begin
    modv_ext = DW'(modv_r);
    if (modv_ext >= den_r) begin
      modv_step = MW'(modv_ext - den_r);
    end else begin
      modv_step = modv_r;
    end
  end

  // Request execution and next-state logic.
  always_comb begin
    st_nxt        = st_r;
    phase_nxt     = phase_r;
    size_nxt      = size_r;
    wpos_nxt      = wpos_r;
    rpos_nxt      = rpos_r;
    work_nxt      = work_r;
    left_nxt      = left_r;
    tcnt_nxt      = tcnt_r;
    modv_nxt      = modv_r;
    den_nxt       = den_r;
    mcnt_nxt      = mcnt_r;
    out_valid_nxt = 1'b0;
    out_st_nxt    = prbe_pkg::ST_OK;
    out_last_nxt  = 1'b0;
    out_data_nxt  = '0;
    ram_we        = 1'b0;
    ram_wdata     = '0;
    ram_re        = 1'b0;
    q_pop         = 1'b0;

    if (cfg_we) begin
      size_nxt  = SW'(cfg_clamp);
      wpos_nxt  = '0;
      rpos_nxt  = '0;
      work_nxt  = '0;
      left_nxt  = '0;
      phase_nxt = PH_IDLE;
      st_nxt    = S_IDLE;
    end else begin
      unique case (st_r)
        S_IDLE: begin
          if (q_fwd.valid) begin
            q_pop = 1'b1;
            unique case (item.op)
              prbe_pkg::OP_WSTART: begin
                if (phase_r != PH_IDLE) begin
                  out_valid_nxt = 1'b1;
                  out_st_nxt    = prbe_pkg::ST_SEQ;
                end else if (room_fail) begin
                  out_valid_nxt = 1'b1;
                  out_st_nxt    = prbe_pkg::ST_AGAIN;
                end else begin
                  work_nxt = wpos_r;
                  if (item.len_zero) begin
                    tcnt_nxt = '0;
                    st_nxt   = S_TRAIL;
                  end else begin
                    left_nxt      = item.length;
                    phase_nxt     = PH_WRITE;
                    out_valid_nxt = 1'b1;
                  end
                end
              end
              prbe_pkg::OP_WBYTE: begin
                if (phase_r != PH_WRITE) begin
                  out_valid_nxt = 1'b1;
                  out_st_nxt    = prbe_pkg::ST_SEQ;
                end else begin
                  ram_we    = 1'b1;
                  ram_wdata = item.data_byte;
                  work_nxt  = work_inc;
                  left_nxt  = left_r - LW'(1);
                  if (left_r == LW'(1)) begin
                    tcnt_nxt = '0;
                    st_nxt   = S_TRAIL;
                  end else begin
                    out_valid_nxt = 1'b1;
                  end
                end
              end
              prbe_pkg::OP_RSTART: begin
                if (phase_r != PH_IDLE) begin
                  out_valid_nxt = 1'b1;
                  out_st_nxt    = prbe_pkg::ST_SEQ;
                end else if (item.len_zero) begin
                  out_valid_nxt = 1'b1;
                  out_st_nxt    = prbe_pkg::ST_INVALID;
                end else if (data_short) begin
                  out_valid_nxt = 1'b1;
                  out_st_nxt    = prbe_pkg::ST_AGAIN;
                end else begin
                  left_nxt = item.length;
                  modv_nxt = MW'(rpos_r) + MW'(item.skip_offset);
                  den_nxt  = DW'(size_r) << (NSTEP - 1);
                  mcnt_nxt = MCW'(NSTEP - 1);
                  st_nxt   = S_MOD;
                end
              end
              prbe_pkg::OP_PSTART: begin
                out_valid_nxt = 1'b1;
                if (phase_r != PH_IDLE) begin
                  out_st_nxt = prbe_pkg::ST_SEQ;
                end else if (data_short) begin
                  out_st_nxt = prbe_pkg::ST_AGAIN;
                end else if (!item.len_zero) begin
                  work_nxt  = rpos_r;
                  left_nxt  = item.length;
                  phase_nxt = PH_PEEK;
                end
              end
              prbe_pkg::OP_RBYTE: begin
                if (phase_r != PH_READ && phase_r != PH_PEEK) begin
                  out_valid_nxt = 1'b1;
                  out_st_nxt    = prbe_pkg::ST_SEQ;
                end else begin
                  ram_re   = 1'b1;
                  work_nxt = work_inc;
                  left_nxt = left_r - LW'(1);
                  st_nxt   = S_RDWAIT;
                end
              end
              default: begin
                out_valid_nxt = 1'b1;
                out_st_nxt    = prbe_pkg::ST_SEQ;
              end
            endcase
          end
        end
        S_MOD: begin
          modv_nxt = modv_step;
          den_nxt  = den_r >> 1;
          mcnt_nxt = mcnt_r - MCW'(1);
          if (mcnt_r == '0) begin
            work_nxt      = AW'(modv_step);
            phase_nxt     = PH_READ;
            out_valid_nxt = 1'b1;
            st_nxt        = S_IDLE;
          end
        end
        S_TRAIL: begin
          ram_we    = 1'b1;
          ram_wdata = trail_byte;
          work_nxt  = work_inc;
          tcnt_nxt  = tcnt_r + 3'd1;
          if (tcnt_r == 3'd7) begin
            wpos_nxt      = work_inc;
            phase_nxt     = PH_IDLE;
            left_nxt      = '0;
            out_valid_nxt = 1'b1;
            out_last_nxt  = 1'b1;
            st_nxt        = S_IDLE;
          end
        end
        S_RDWAIT: begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = ram_rdata;
          if (left_r == '0) begin
            out_last_nxt = 1'b1;
            phase_nxt    = PH_IDLE;
            if (phase_r == PH_READ) begin
              rpos_nxt = rd_commit;
            end
          end
          st_nxt = S_IDLE;
        end
        default: begin
          st_nxt = S_IDLE;
        end
      endcase
    end
  end

  // State, indices and registered result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      phase_r     <= PH_IDLE;
      size_r      <= SW'(RING_BYTES);
      wpos_r      <= '0;
      rpos_r      <= '0;
      work_r      <= '0;
      left_r      <= '0;
      tcnt_r      <= '0;
      mcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      phase_r     <= phase_nxt;
      size_r      <= size_nxt;
      wpos_r      <= wpos_nxt;
      rpos_r      <= rpos_nxt;
      work_r      <= work_nxt;
      left_r      <= left_nxt;
      tcnt_r      <= tcnt_nxt;
      mcnt_r      <= mcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    modv_r     <= modv_nxt;
    den_r      <= den_nxt;
    out_st_r   <= out_st_nxt;
    out_last_r <= out_last_nxt;
    out_data_r <= out_data_nxt;
  end

  // Ring memory.
  prbe_ram #(
    .WIDTH (8),
    .DEPTH (RING_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (work_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (work_r),
    .rdata (ram_rdata)
  );

  // Result port; the space counts follow the indices as they stand after the request.
  assign out_valid             = out_valid_r;
  assign out_rsp.status        = out_st_r;
  assign out_rsp.read_data     = out_data_r;
  assign out_rsp.last          = out_last_r;
  assign out_rsp.avail_read    = AVW'(rdbl_w);
  assign out_rsp.avail_write   = AVW'(free_w);

  // Ring size stays in range and every index stays inside the ring.
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    (size_r >= SW'(prbe_pkg::MIN_SIZE)) && (size_r <= SW'(RING_BYTES)) &&
    (SW'(wpos_r) < size_r) && (SW'(rpos_r) < size_r) && (SW'(work_r) < size_r))
    else $error("ring index outside the ring size");

  // An open write run has payload bytes left until its trailer is being written.
  a_write_left: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_WRITE && st_r != S_TRAIL) |-> (left_r != '0))
    else $error("write run open with no bytes left");

  // The last trailer byte produces a result that closes the run.
  a_trail_done: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_TRAIL && tcnt_r == 3'd7 && !cfg_we) |=> (out_valid_r && out_last_r))
    else $error("trailer finished without a closing result");

  // A refused request never ends a run.
  a_err_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_st_r != prbe_pkg::ST_OK) |-> !out_last_r)
    else $error("refused request marked last");

endmodule

`default_nettype wire

/* design/packet_ring_buffer_engine.sv */
// Top level of the packet ring buffer engine.
`default_nettype none

// Each request accepted on start (while busy is low) yields exactly one result, shown for a
// single cycle on out_valid/out_rsp; the receiver cannot stall, so results must be taken as
// they appear. Requests enter a two-entry queue, and busy is high while it is full. The
// executing back end finishes write_start, write_byte, peek_start and refused requests
// straight from its idle state; read_byte waits on a registered read of the ring memory, a
// packet close adds one ring write per trailer byte, and an accepted read_start first runs a
// bit-per-cycle modulo of the skip offset by the ring size. Each result is registered and
// appears in the cycle after its request finishes execution. Writes to the size register
// clear all indices and are meant for idle periods only.
module packet_ring_buffer_engine #(
  parameter int RING_BYTES = 4096
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire prbe_pkg::in_req_t   in_req,
  output logic                     out_valid,
  output prbe_pkg::out_rsp_t       out_rsp,
  input  wire logic                cfg_we,
  input  wire prbe_pkg::cfg_size_t cfg_data
);

  prbe_pkg::q_fwd_t q_fwd;
  logic             q_pop;

  // Request intake and classification.
  prbe_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .in_req (in_req),
    .q_fwd  (q_fwd),
    .q_pop  (q_pop)
  );

  // Request execution.
  prbe_back #(
    .RING_BYTES (RING_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_fwd     (q_fwd),
    .q_pop     (q_pop),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_rsp   (out_rsp)
  );

endmodule

`default_nettype wire

/* tb/sv/tb_packet_ring_buffer_engine.sv */
// Self-checking testbench for the packet ring buffer engine.
`default_nettype none

module tb_packet_ring_buffer_engine;

  localparam int RING_BYTES    = 4096;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_REQS   = 1850;
  localparam int SIZE_STEPS    = 12;
  localparam int SETTLE_CYCLES = 24;

  // Mode codes that the block does not define.
  localparam logic [2:0] MODE_BAD_FIRST = 3'd5;
  localparam logic [2:0] MODE_BAD_LAST  = 3'd7;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_WRITE,
    PH_READ,
    PH_PEEK
  } ring_phase_t;

  // A request together with the result it must produce.
  typedef struct packed {
    prbe_pkg::in_req_t  req;
    prbe_pkg::out_rsp_t rsp;
  } req_entry_t;

  logic                clk;
  logic                rst_n    = 1'b0;
  logic                start    = 1'b0;
  logic                busy;
  prbe_pkg::in_req_t   in_req   = '0;
  logic                out_valid;
  prbe_pkg::out_rsp_t  out_rsp;
  logic                cfg_we   = 1'b0;
  prbe_pkg::cfg_size_t cfg_data = '0;

  packet_ring_buffer_engine #(
    .RING_BYTES(RING_BYTES)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_rsp  (out_rsp),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  // Clock with a 10 unit period.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Shadow copy of the ring and its indices.
  logic [7:0]          ring_img [RING_BYTES];
  bit                  ring_set [RING_BYTES];
  int unsigned         rd_pos;
  int unsigned         wr_pos;
  int unsigned         wk_pos;
  prbe_pkg::len_t      left_cnt;
  ring_phase_t         run_phase;
  prbe_pkg::cfg_size_t size_reg;

  // Requests waiting to be driven and results owed by the block.
  req_entry_t          req_pend_q[$];
  prbe_pkg::out_rsp_t  rsp_due_q[$];
  prbe_pkg::out_rsp_t  cur_rsp = '0;
  prbe_pkg::out_rsp_t  last_rsp;

  // Stimulus bookkeeping.
  int          pkt_len_q[$];
  bit          aligned;
  int          gap_max = 3;
  int          gap_left = 0;
  bit          req_taken = 1'b0;
  int          req_total = 0;
  int          size_cnt = 0;

  // Run statistics.
  int          cycle_cnt = 0;
  int          err_cnt = 0;
  int          rsp_cnt = 0;
  int          ends_cnt = 0;
  int          status_seen [4];

  // The ring size in effect, with the register saturated to the legal range.
  function automatic int unsigned live_size();
    if (size_reg < prbe_pkg::MIN_SIZE) return prbe_pkg::MIN_SIZE;
    if (size_reg > RING_BYTES) return RING_BYTES;
    return size_reg;
  endfunction

  function automatic int unsigned ring_free();
    int unsigned s;
    s = live_size();
    if (wr_pos >= rd_pos) return s - (wr_pos - rd_pos);
    return rd_pos - wr_pos;
  endfunction

  function automatic void ring_put(logic [7:0] b);
    int unsigned s;
    s = live_size();
    ring_img[wk_pos % s] = b;
    ring_set[wk_pos % s] = 1'b1;
    wk_pos = (wk_pos + 1) % s;
  endfunction

  // Close a packet: four zero bytes, then the packet's start index, low byte first.
  function automatic void ring_close();
    int i;
    for (i = 0; i < 4; i++) ring_put(8'h00);
    for (i = 0; i < 4; i++) ring_put(8'(wr_pos >> (8 * i)));
    wr_pos    = wk_pos;
    run_phase = PH_IDLE;
    left_cnt  = '0;
  endfunction

  // A size write clears every index; old bytes are no longer trusted.
  function automatic void ring_clear(prbe_pkg::cfg_size_t v);
    size_reg  = v;
    rd_pos    = 0;
    wr_pos    = 0;
    wk_pos    = 0;
    left_cnt  = '0;
    run_phase = PH_IDLE;
    foreach (ring_set[i]) ring_set[i] = 1'b0;
  endfunction

  // Apply one request to the shadow ring and return the result it yields.
  function automatic prbe_pkg::out_rsp_t ring_predict(prbe_pkg::in_req_t r);
    prbe_pkg::out_rsp_t o;
    int unsigned        s;
    int unsigned        fr;
    s = live_size();
    o = '0;
    o.status = prbe_pkg::ST_OK;
    case (r.mode)
      prbe_pkg::MODE_WSTART: begin
        if (run_phase != PH_IDLE) o.status = prbe_pkg::ST_SEQ;
        else if (ring_free() <= r.length + prbe_pkg::TRAILER_BYTES)
          o.status = prbe_pkg::ST_AGAIN;
        else begin
          wk_pos = wr_pos;
          if (r.length == 0) begin
            ring_close();
            o.last = 1'b1;
          end else begin
            left_cnt  = r.length;
            run_phase = PH_WRITE;
          end
        end
      end
      prbe_pkg::MODE_WBYTE: begin
        if (run_phase != PH_WRITE) o.status = prbe_pkg::ST_SEQ;
        else begin
          ring_put(r.data_byte);
          left_cnt = left_cnt - 1'b1;
          if (left_cnt == 0) begin
            ring_close();
            o.last = 1'b1;
          end
        end
      end
      prbe_pkg::MODE_RSTART, prbe_pkg::MODE_PSTART: begin
        if (run_phase != PH_IDLE) o.status = prbe_pkg::ST_SEQ;
        else if (r.mode == prbe_pkg::MODE_RSTART && r.length == 0)
          o.status = prbe_pkg::ST_INVALID;
        else if (s - ring_free() < r.length) o.status = prbe_pkg::ST_AGAIN;
        else if (r.length != 0) begin
          left_cnt = r.length;
          if (r.mode == prbe_pkg::MODE_RSTART) begin
            wk_pos    = (rd_pos + r.skip_offset) % s;
            run_phase = PH_READ;
          end else begin
            wk_pos    = rd_pos;
            run_phase = PH_PEEK;
          end
        end
      end
      prbe_pkg::MODE_RBYTE: begin
        if (run_phase != PH_READ && run_phase != PH_PEEK) o.status = prbe_pkg::ST_SEQ;
        else begin
          o.read_data = ring_img[wk_pos % s];
          wk_pos      = (wk_pos + 1) % s;
          left_cnt    = left_cnt - 1'b1;
          if (left_cnt == 0) begin
            o.last = 1'b1;
            // A consuming read also steps over the trailer.
            if (run_phase == PH_READ) rd_pos = (wk_pos + prbe_pkg::TRAILER_BYTES) % s;
            run_phase = PH_IDLE;
          end
        end
      end
      default: o.status = prbe_pkg::ST_SEQ;
    endcase
    fr = ring_free();
    o.avail_read  = prbe_pkg::avail_t'(s - fr);
    o.avail_write = prbe_pkg::avail_t'(fr);
    return o;
  endfunction

  // True when every byte of a read run has been written since the last size change.
  function automatic bit span_written(int unsigned from, int unsigned n);
    int unsigned s;
    int unsigned i;
    s = live_size();
    for (i = 0; i < n; i++) if (!ring_set[(from + i) % s]) return 1'b0;
    return 1'b1;
  endfunction

  // Queue one request with its expected result.
  task automatic push_req(logic [2:0] mode, logic [7:0] dat, prbe_pkg::len_t len,
                          prbe_pkg::len_t off);
    req_entry_t e;
    e.req.mode        = mode;
    e.req.data_byte   = dat;
    e.req.length      = len;
    e.req.skip_offset = off;
    e.rsp             = ring_predict(e.req);
    last_rsp          = e.rsp;
    req_pend_q.push_back(e);
    req_total++;
    while (req_pend_q.size() > 8) @(posedge clk);
  endtask

  // A request that the current phase does not allow, with random fields.
  task automatic push_stray(ring_phase_t ph);
    logic [2:0] m;
    do m = 3'($urandom);
    while (m < MODE_BAD_FIRST &&
           (ph == PH_IDLE  ? (m == prbe_pkg::MODE_WSTART || m == prbe_pkg::MODE_RSTART ||
                              m == prbe_pkg::MODE_PSTART) :
            ph == PH_WRITE ? (m == prbe_pkg::MODE_WBYTE) : (m == prbe_pkg::MODE_RBYTE)));
    push_req(m, 8'($urandom), prbe_pkg::len_t'($urandom), prbe_pkg::len_t'($urandom));
  endtask

  // Stream bytes until the open write or read run ends, with the odd stray request.
  task automatic finish_run();
    while (run_phase != PH_IDLE) begin
      if ($urandom_range(0, 19) == 0) push_stray(run_phase);
      else if (run_phase == PH_WRITE)
        push_req(prbe_pkg::MODE_WBYTE, 8'($urandom), prbe_pkg::len_t'($urandom),
                 prbe_pkg::len_t'($urandom));
      else
        push_req(prbe_pkg::MODE_RBYTE, 8'($urandom), prbe_pkg::len_t'($urandom),
                 prbe_pkg::len_t'($urandom));
    end
  endtask

  // Write one packet; the length sits mostly low, sometimes on the room boundary.
  task automatic put_packet();
    int unsigned fr;
    int          max_len;
    int          n;
    int          pick;
    fr      = ring_free();
    max_len = int'(fr) - prbe_pkg::TRAILER_BYTES - 1;
    pick    = $urandom_range(0, 9);
    if (max_len < 0) n = $urandom_range(0, 4095);
    else if (pick == 0) n = max_len + 1;
    else if (pick == 1 && max_len <= 64) n = max_len;
    else if (pick == 2) n = $urandom_range(0, (max_len < 300) ? max_len : 300);
    else n = $urandom_range(0, (max_len < 24) ? max_len : 24);
    push_req(prbe_pkg::MODE_WSTART, 8'($urandom), prbe_pkg::len_t'(n),
             prbe_pkg::len_t'($urandom));
    if (last_rsp.status == prbe_pkg::ST_OK) pkt_len_q.push_back(n);
    finish_run();
  endtask

  // Consume the oldest packet, skipping empty ones by offset, maybe peeking first.
  task automatic take_packet();
    int unsigned s;
    int          k;
    int          n;
    int          p;
    s = live_size();
    k = 0;
    while (k < pkt_len_q.size() && pkt_len_q[k] == 0) k++;
    if (k == pkt_len_q.size()) begin
      // Only empty packets are queued: look at the head trailer.
      push_req(prbe_pkg::MODE_PSTART, 8'($urandom), prbe_pkg::len_t'(prbe_pkg::TRAILER_BYTES),
               prbe_pkg::len_t'($urandom));
      finish_run();
    end else begin
      n = pkt_len_q[k];
      if ($urandom_range(0, 2) == 0) begin
        p = $urandom_range(1, n);
        if (span_written(rd_pos, p)) begin
          push_req(prbe_pkg::MODE_PSTART, 8'($urandom), prbe_pkg::len_t'(p),
                   prbe_pkg::len_t'($urandom));
          finish_run();
        end
      end
      if (span_written((rd_pos + k * prbe_pkg::TRAILER_BYTES) % s, n)) begin
        repeat (k + 1) void'(pkt_len_q.pop_front());
        push_req(prbe_pkg::MODE_RSTART, 8'($urandom), prbe_pkg::len_t'(n),
                 prbe_pkg::len_t'(k * prbe_pkg::TRAILER_BYTES));
        finish_run();
      end else begin
        push_stray(PH_IDLE);
      end
    end
  endtask

  // Read or peek an arbitrary span; a consuming one loses track of packet bounds.
  task automatic take_span();
    int unsigned s;
    int unsigned rdable;
    int unsigned n;
    int unsigned off;
    int unsigned from;
    bit          peek;
    s      = live_size();
    rdable = s - ring_free();
    if (rdable == 0) begin
      push_req(($urandom_range(0, 1) != 0) ? prbe_pkg::MODE_RSTART : prbe_pkg::MODE_PSTART,
               8'($urandom), prbe_pkg::len_t'($urandom_range(1, 4095)),
               prbe_pkg::len_t'($urandom));
    end else begin
      n    = $urandom_range(1, (rdable < 40) ? rdable : 40);
      off  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 16);
      peek = ($urandom_range(0, 2) == 0);
      from = peek ? rd_pos : (rd_pos + off) % s;
      if (!span_written(from, n)) begin
        push_stray(PH_IDLE);
      end else begin
        push_req(peek ? prbe_pkg::MODE_PSTART : prbe_pkg::MODE_RSTART, 8'($urandom),
                 prbe_pkg::len_t'(n), prbe_pkg::len_t'(off));
        if (!peek) begin
          aligned = 1'b0;
          pkt_len_q.delete();
        end
        finish_run();
      end
    end
  endtask

  // Requests refused for room or length, and the zero-length peek.
  task automatic push_refused();
    int unsigned fr;
    int unsigned rdable;
    fr     = ring_free();
    rdable = live_size() - fr;
    case ($urandom_range(0, 3))
      0: push_req(prbe_pkg::MODE_WSTART, 8'($urandom),
                  prbe_pkg::len_t'($urandom_range((fr > prbe_pkg::TRAILER_BYTES) ?
                                                  fr - prbe_pkg::TRAILER_BYTES : 0, 4095)),
                  prbe_pkg::len_t'($urandom));
      1: begin
        if (rdable < 4095)
          push_req(($urandom_range(0, 1) != 0) ? prbe_pkg::MODE_RSTART :
                   prbe_pkg::MODE_PSTART, 8'($urandom),
                   prbe_pkg::len_t'($urandom_range(rdable + 1, 4095)),
                   prbe_pkg::len_t'($urandom));
        else
          push_stray(PH_IDLE);
      end
      2: push_req(prbe_pkg::MODE_RSTART, 8'($urandom), '0, prbe_pkg::len_t'($urandom));
      default: push_req(prbe_pkg::MODE_PSTART, 8'($urandom), '0, prbe_pkg::len_t'($urandom));
    endcase
  endtask

  // Hold the sender until every owed result has arrived.
  task automatic wait_drain();
    while (req_pend_q.size() != 0 || start || rsp_due_q.size() != 0 || busy)
      @(posedge clk);
  endtask

  // Change the ring size while the block is idle.
  task automatic write_size(prbe_pkg::cfg_size_t v);
    wait_drain();
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we   <= 1'b0;
    ring_clear(v);
    aligned = 1'b1;
    pkt_len_q.delete();
    size_cnt++;
  endtask

  // Request driver: one request per handshake, with a random gap after each.
  always @(negedge clk) begin : drive_blk
    logic       nxt_start;
    req_entry_t nxt;
    nxt_start = start;
    nxt.req   = in_req;
    nxt.rsp   = cur_rsp;
    if (rst_n) begin
      if (start && req_taken) begin
        nxt_start = 1'b0;
        gap_left  = $urandom_range(0, gap_max);
      end
      if (!nxt_start) begin
        if (gap_left > 0) gap_left--;
        else if (req_pend_q.size() != 0) begin
          nxt       = req_pend_q.pop_front();
          nxt_start = 1'b1;
        end
      end
    end
    start   <= nxt_start;
    in_req  <= nxt.req;
    cur_rsp <= nxt.rsp;
  end

  // Result checker: each result must match the oldest owed one, field by field.
  always @(posedge clk) begin : check_blk
    prbe_pkg::out_rsp_t want;
    cycle_cnt <= cycle_cnt + 1;
    if (rst_n && out_valid) begin
      if (rsp_due_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("ERROR: result with no request pending: status %0d data %02x last %0d",
                   out_rsp.status, out_rsp.read_data, out_rsp.last);
      end else begin
        want = rsp_due_q.pop_front();
        rsp_cnt++;
        status_seen[want.status]++;
        if (want.last) ends_cnt++;
        if (out_rsp.status !== want.status || out_rsp.read_data !== want.read_data ||
            out_rsp.last !== want.last || out_rsp.avail_read !== want.avail_read ||
            out_rsp.avail_write !== want.avail_write) begin
          err_cnt++;
          if (err_cnt <= 10) begin
            $display("ERROR: result %0d (expected/got): status %0d/%0d data %02x/%02x",
                     rsp_cnt, want.status, out_rsp.status, want.read_data,
                     out_rsp.read_data);
            $display("       last %0d/%0d avail_read %0d/%0d avail_write %0d/%0d",
                     want.last, out_rsp.last, want.avail_read, out_rsp.avail_read,
                     want.avail_write, out_rsp.avail_write);
          end
        end
      end
    end
    if (rst_n && start && !busy) rsp_due_q.push_back(cur_rsp);
    req_taken <= rst_n && start && !busy;
  end

  // Watchdog on the whole run.
  initial begin : watchdog
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("ERROR: run stopped at the cycle limit with %0d results owed", rsp_due_q.size());
    $display("*** FAILED ***");
    $finish;
  end

  // Stimulus: reset, directed corner cases, then random traffic over several ring sizes.
  initial begin : stim
    prbe_pkg::cfg_size_t v;
    int                  step;
    int                  base;
    int                  budget;
    int                  pick;
    ring_clear(prbe_pkg::cfg_size_t'(RING_BYTES));
    aligned = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Requests out of sequence, bad lengths and refusals on an empty ring.
    push_req(prbe_pkg::MODE_RBYTE, 8'($urandom), '1, '1);
    push_req(MODE_BAD_LAST, '1, '1, '1);
    push_req(prbe_pkg::MODE_RSTART, 8'($urandom), '0, '0);
    push_req(prbe_pkg::MODE_PSTART, 8'($urandom), '0, '1);
    push_req(prbe_pkg::MODE_RSTART, 8'($urandom), prbe_pkg::len_t'(1), '1);
    push_req(prbe_pkg::MODE_WSTART, 8'($urandom), '1, '0);
    // An empty packet, then a three byte one with extreme data.
    push_req(prbe_pkg::MODE_WSTART, 8'($urandom), '0, '0);
    push_req(prbe_pkg::MODE_WSTART, 8'($urandom), prbe_pkg::len_t'(3), '0);
    push_req(prbe_pkg::MODE_WBYTE, 8'h00, '1, '1);
    push_req(prbe_pkg::MODE_WBYTE, 8'hFF, '0, '0);
    push_req(prbe_pkg::MODE_WBYTE, 8'hA5, '1, '1);
    // Peek into the empty packet's trailer, then read the second packet past it.
    push_req(prbe_pkg::MODE_PSTART, 8'($urandom), prbe_pkg::len_t'(2), '0);
    push_req(prbe_pkg::MODE_RBYTE, 8'($urandom), '0, '0);
    push_req(prbe_pkg::MODE_RBYTE, 8'($urandom), '0, '0);
    push_req(prbe_pkg::MODE_RSTART, 8'($urandom), prbe_pkg::len_t'(3),
             prbe_pkg::len_t'(prbe_pkg::TRAILER_BYTES));
    push_req(prbe_pkg::MODE_WSTART, 8'($urandom), '0, '0);
    push_req(prbe_pkg::MODE_RBYTE, 8'($urandom), '0, '0);
    push_req(prbe_pkg::MODE_RBYTE, 8'($urandom), '0, '0);
    push_req(prbe_pkg::MODE_RBYTE, 8'($urandom), '0, '0);
    // A size below the minimum, and the room check on both sides of the boundary.
    write_size(prbe_pkg::cfg_size_t'(5));
    push_req(prbe_pkg::MODE_WSTART, 8'($urandom), prbe_pkg::len_t'(8), '0);
    push_req(prbe_pkg::MODE_WSTART, 8'($urandom), prbe_pkg::len_t'(7), '0);
    finish_run();

    // Random traffic, one ring size per step; every third step runs without gaps.
    budget = RANDOM_REQS / SIZE_STEPS;
    for (step = 0; step < SIZE_STEPS; step++) begin
      case (step)
        0:       v = prbe_pkg::cfg_size_t'(16);
        1:       v = '1;
        2:       v = prbe_pkg::cfg_size_t'(40);
        3:       v = '0;
        4:       v = prbe_pkg::cfg_size_t'(RING_BYTES);
        5:       v = prbe_pkg::cfg_size_t'(100);
        6:       v = prbe_pkg::cfg_size_t'(17);
        7:       v = prbe_pkg::cfg_size_t'(RING_BYTES + 1);
        8:       v = prbe_pkg::cfg_size_t'(64);
        9:       v = prbe_pkg::cfg_size_t'(23);
        10:      v = prbe_pkg::cfg_size_t'($urandom_range(16, 300));
        default: v = prbe_pkg::cfg_size_t'($urandom);
      endcase
      write_size(v);
      gap_max = (step % 3 == 2) ? 0 : 3;
      base = req_total;
      while (req_total - base < budget) begin
        if (run_phase == PH_IDLE && rd_pos == wr_pos) begin
          aligned = 1'b1;
          pkt_len_q.delete();
        end
        pick = $urandom_range(0, 99);
        if (pick < 40) put_packet();
        else if (pick < 72) begin
          if (aligned && pkt_len_q.size() != 0) take_packet();
          else take_span();
        end
        else if (pick < 82) take_span();
        else if (pick < 92) push_refused();
        else if (pick < 97) push_stray(PH_IDLE);
        else wait_drain();
      end
    end

    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Run covered %0d requests and %0d checked results over %0d size settings.",
             req_total, rsp_cnt, size_cnt + 1);
    $display("Results seen: %0d ok, %0d again, %0d invalid, %0d out of sequence, %0d run ends.",
             status_seen[prbe_pkg::ST_OK], status_seen[prbe_pkg::ST_AGAIN],
             status_seen[prbe_pkg::ST_INVALID], status_seen[prbe_pkg::ST_SEQ], ends_cnt);
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches in total", err_cnt);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
